>>> rtl/bap_pkg.sv
// Shared types and constants for the advertising report parser.
`default_nettype none
package bap_pkg;

	localparam int unsigned DATA_START = 11;
	localparam logic [7:0]  NO_FLAGS   = 8'hFF;
	localparam logic [7:0]  PRINT_LO   = 8'h20;
	localparam logic [7:0]  PRINT_HI   = 8'h7E;

	// configuration register indexes
	typedef enum logic [1:0] {
		REG_REPLACEMENT = 2'd0,
		REG_FLAGS_TYPE  = 2'd1,
		REG_NAME_TYPE   = 2'd2,
		REG_SERVICE_TYPE = 2'd3
	} reg_idx_t;

	typedef enum logic [2:0] {
		KIND_ADDR      = 3'd0,
		KIND_FLAGS     = 3'd1,
		KIND_NAME_START = 3'd2,
		KIND_NAME_CHAR = 3'd3,
		KIND_SVC_START = 3'd4,
		KIND_UUID      = 3'd5,
		KIND_SVC_BYTE  = 3'd6,
		KIND_END       = 3'd7
	} kind_t;

	typedef struct packed {
		logic [7:0] replacement_char;
		logic [7:0] flags_type_code;
		logic [7:0] name_type_code;
		logic [7:0] service_type_code;
	} cfg_t;

	typedef struct packed {
		logic        valid;
		kind_t       kind;
		logic [47:0] value;
		logic [7:0]  final_flags;
		logic        last;
	} res_t;

endpackage
`default_nettype wire

>>> rtl/bap_core.sv
// Parser state and per-byte decode of the report and its AD structures.
`default_nettype none
module bap_core (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          step,
	input  wire logic [7:0]    data_byte,
	input  wire logic          first_byte,
	input  wire bap_pkg::cfg_t cfg,
	output bap_pkg::res_t      res
);
	import bap_pkg::*;

	typedef enum logic [2:0] {
		PH_IDLE,
		PH_HEADER,
		PH_ADLEN,
		PH_ADBODY,
		PH_DONE
	} phase_t;

	phase_t      phase_q, phase_n;
	logic [8:0]  pos_q, pos_n;
	logic [7:0]  dlen_q, dlen_n;
	logic [47:0] addr_q, addr_n;
	logic [7:0]  rem_q, rem_n;
	logic [7:0]  stype_q, stype_n;
	logic [7:0]  off_q, off_n;
	logic [7:0]  uuid_lo_q, uuid_lo_n;
	logic [7:0]  flags_q, flags_n;

	logic [8:0] pos_end;
	logic [8:0] left;
	logic [8:0] total;
	logic [2:0] lane;
	logic       svc_ok;
	logic [7:0] name_c;

	always_comb begin
		pos_end = 9'(DATA_START) + {1'b0, dlen_q};
		left    = pos_end - pos_q - 9'd1;
		total   = {1'b0, off_q} + {1'b0, rem_q};
		svc_ok  = (total >= 9'd3);
		lane    = 3'(pos_q - 9'd4);
		name_c  = (data_byte >= PRINT_LO && data_byte <= PRINT_HI) ? data_byte
			: cfg.replacement_char;

		phase_n   = phase_q;
		pos_n     = pos_q;
		dlen_n    = dlen_q;
		addr_n    = addr_q;
		rem_n     = rem_q;
		stype_n   = stype_q;
		off_n     = off_q;
		uuid_lo_n = uuid_lo_q;
		flags_n   = flags_q;

		res.valid       = 1'b0;
		res.kind        = KIND_ADDR;
		res.value       = '0;
		res.final_flags = '0;
		res.last        = 1'b0;

		if (first_byte) begin
			phase_n   = PH_HEADER;
			pos_n     = 9'd1;
			dlen_n    = '0;
			addr_n    = '0;
			rem_n     = '0;
			stype_n   = '0;
			off_n     = '0;
			uuid_lo_n = '0;
			flags_n   = NO_FLAGS;
		end else if (phase_q != PH_IDLE && phase_q != PH_DONE) begin
			pos_n = pos_q + 9'd1;
			if (pos_q < 9'(DATA_START)) begin
				if (pos_q >= 9'd4 && pos_q <= 9'd9) begin
					for (int i = 0; i < 6; i++) begin
						if (lane == 3'(i))
							addr_n[8*i +: 8] = addr_q[8*i +: 8] | data_byte;
					end
				end
				if (pos_q == 9'd9) begin
					res.valid = 1'b1;
					res.kind  = KIND_ADDR;
					res.value = addr_n;
				end
				if (pos_q == 9'd10) begin
					dlen_n  = data_byte;
					phase_n = PH_ADLEN;
				end
			end else if (pos_q == pos_end) begin
				res.valid       = 1'b1;
				res.kind        = KIND_END;
				res.value       = {40'd0, data_byte};
				res.final_flags = flags_q;
				res.last        = 1'b1;
				phase_n         = PH_DONE;
			end else if (phase_q == PH_ADLEN) begin
				// clip the structure to what is left of the data region
				if ({1'b0, data_byte} < left)
					rem_n = data_byte;
				else
					rem_n = left[7:0];
				off_n = '0;
				if (rem_n != 8'd0)
					phase_n = PH_ADBODY;
				else
					rem_n = rem_q;
			end else begin
				if (off_q == 8'd0) begin
					stype_n = data_byte;
					if (data_byte == cfg.flags_type_code) begin
						res.valid = 1'b0;
					end else if (data_byte == cfg.name_type_code) begin
						res.valid = 1'b1;
						res.kind  = KIND_NAME_START;
						res.value = {39'd0, total - 9'd1};
					end else if (data_byte == cfg.service_type_code && svc_ok) begin
						res.valid = 1'b1;
						res.kind  = KIND_SVC_START;
						res.value = {39'd0, total - 9'd3};
					end
				end else if (stype_q == cfg.flags_type_code) begin
					if (off_q == 8'd1) begin
						flags_n   = data_byte;
						res.valid = 1'b1;
						res.kind  = KIND_FLAGS;
						res.value = {40'd0, data_byte};
					end
				end else if (stype_q == cfg.name_type_code) begin
					res.valid = 1'b1;
					res.kind  = KIND_NAME_CHAR;
					res.value = {40'd0, name_c};
				end else if (stype_q == cfg.service_type_code && svc_ok) begin
					if (off_q == 8'd1) begin
						uuid_lo_n = data_byte;
					end else if (off_q == 8'd2) begin
						res.valid = 1'b1;
						res.kind  = KIND_UUID;
						res.value = {32'd0, data_byte, uuid_lo_q};
					end else begin
						res.valid = 1'b1;
						res.kind  = KIND_SVC_BYTE;
						res.value = {40'd0, data_byte};
					end
				end
				off_n = off_q + 8'd1;
				rem_n = rem_q - 8'd1;
				if (rem_q == 8'd1)
					phase_n = PH_ADLEN;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_IDLE;
			pos_q     <= '0;
			dlen_q    <= '0;
			addr_q    <= '0;
			rem_q     <= '0;
			stype_q   <= '0;
			off_q     <= '0;
			uuid_lo_q <= '0;
			flags_q   <= NO_FLAGS;
		end else if (step) begin
			phase_q   <= phase_n;
			pos_q     <= pos_n;
			dlen_q    <= dlen_n;
			addr_q    <= addr_n;
			rem_q     <= rem_n;
			stype_q   <= stype_n;
			off_q     <= off_n;
			uuid_lo_q <= uuid_lo_n;
			flags_q   <= flags_n;
		end
	end

endmodule
`default_nettype wire

>>> rtl/ble_adv_report_parser_top.sv
// Top level of the advertising report parser: channels, registers, checks.
//
// channel   direction  handshake           payload
// in        to block   in_valid/in_ready   data_byte, first_byte
// out       from block out_valid/out_ready result_kind, value, final_flags, last
// cfg       to block   cfg_we              cfg_index, cfg_wdata
//
// One byte per cycle sustained while results are taken; two register stages
// (input register, then decode into the result register), so a byte's result
// is presented from the result register once the decode stage has taken it.
// arst_n clears control state and loads the register reset values.
// A stalled result holds the decode stage; the input register still takes
// one byte, after which in_ready falls until the result is taken.
`default_nettype none
module ble_adv_report_parser_top (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// byte input
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [7:0]  data_byte,
	input  wire logic        first_byte,
	// result output
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [2:0]       result_kind,
	output logic [47:0]      value,
	output logic [7:0]       final_flags,
	output logic             last,
	// register writes
	input  wire logic        cfg_we,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [7:0]  cfg_wdata
);
	import bap_pkg::*;

	cfg_t        cfg_q;
	logic        valid_s1;
	logic [7:0]  byte_s1;
	logic        first_s1;
	logic        out_valid_q;
	res_t        res;
	res_t        res_q;
	logic        fire;

	// decode stage moves when the result slot is free or being emptied
	assign fire     = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || fire;

	// register file
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.replacement_char  <= 8'd63;
			cfg_q.flags_type_code   <= 8'd1;
			cfg_q.name_type_code    <= 8'd9;
			cfg_q.service_type_code <= 8'd22;
		end else if (cfg_we) begin
			case (reg_idx_t'(cfg_index))
				REG_REPLACEMENT:  cfg_q.replacement_char  <= cfg_wdata;
				REG_FLAGS_TYPE:   cfg_q.flags_type_code   <= cfg_wdata;
				REG_NAME_TYPE:    cfg_q.name_type_code    <= cfg_wdata;
				REG_SERVICE_TYPE: cfg_q.service_type_code <= cfg_wdata;
				default:          cfg_q <= cfg_q;
			endcase
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			byte_s1  <= data_byte;
			first_s1 <= first_byte;
		end
	end

	bap_core u_core (
		.clk        (clk),
		.arst_n     (arst_n),
		.step       (fire),
		.data_byte  (byte_s1),
		.first_byte (first_s1),
		.cfg        (cfg_q),
		.res        (res)
	);

	// result register; bytes that give no result just pass through
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fire) begin
			out_valid_q <= res.valid;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire && res.valid)
			res_q <= res;
	end

	assign out_valid   = out_valid_q;
	assign result_kind = res_q.kind;
	assign value       = res_q.value;
	assign final_flags = res_q.final_flags;
	assign last        = res_q.last;

	// checks
	a_last_is_end: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (res_q.last == (res_q.kind == KIND_END)))
		else $error("last flag disagrees with result kind");

	a_flags_only_at_end: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !res_q.last) |-> (res_q.final_flags == 8'd0))
		else $error("final flags set on a result that does not end the report");

	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> (valid_s1 && out_valid_q && !out_ready))
		else $error("input stalled without a stalled result");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !out_ready) |=> (out_valid_q && $stable(res_q)))
		else $error("pending result lost or overwritten");

endmodule
`default_nettype wire
